/* rtl/core/delimited_frame_receiver_xor_defines.svh */
// Assertion macros shared by the RTL of the delimited frame receiver.
`ifndef DELIMITED_FRAME_RECEIVER_XOR_DEFINES_SVH
`define DELIMITED_FRAME_RECEIVER_XOR_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define DFRX_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define DFRX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/dfrx_pkg.sv */
package dfrx_pkg;

   localparam int BYTE_W          = 8;
   localparam int COUNT_W         = 5;
   localparam int BUFFER_BYTES_DEF = 32;
   localparam int MIN_FRAME_BYTES = 4;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 8;

   localparam logic [BYTE_W-1:0] START_DELIM_RESET = 8'd170;
   localparam logic [BYTE_W-1:0] END_DELIM_RESET   = 8'd85;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_DELIM = 1'b0,
      CSR_END_DELIM   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_SUM  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

endpackage

/* rtl/core/dfrx_channels.sv */
// Input channel: one received byte per item.
interface dfrx_req_if import dfrx_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel: one frame status or one parameter per item.
interface dfrx_rsp_if import dfrx_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [BYTE_W-1:0]  command_code;
   logic [COUNT_W-1:0] param_count;
   logic               param_valid;
   logic [COUNT_W-1:0] param_index;
   logic [BYTE_W-1:0]  param_byte;
   logic               last;

   modport source (output valid, output status, output command_code, output param_count,
                   output param_valid, output param_index, output param_byte,
                   output last, input ready);
   modport sink   (input valid, input status, input command_code, input param_count,
                   input param_valid, input param_index, input param_byte,
                   input last, output ready);
endinterface

/* rtl/core/delimited_frame_receiver_xor.sv */
// Delimited frame receiver with XOR checksum. Each input item is one received byte.
// While no frame is open, bytes are dropped until one equals the start delimiter;
// that byte opens a frame and every later byte is written to an on-chip buffer of
// BUFFER_BYTES entries. A byte equal to the end delimiter closes the frame once at
// least four bytes (start and end included) are held; the frame layout is start,
// command, parameters, checksum, end. Bytes are taken at one per cycle while a
// frame is being collected. When a frame closes, the receiver stops taking items
// while one shared XOR unit sweeps the buffer through its single read port: one
// byte per cycle over the command, parameter and checksum bytes, then the last
// registered read and the decision. An accepted frame is then sent as one result
// item per parameter, each through a buffer read and then the result register
// load, waiting longer if the sink stalls; a frame without parameters, a checksum
// mismatch or a full buffer gives a single status item. The buffer needs no
// clearing after reset, because only entries written in the current frame are
// ever read. The start and end delimiters are written through the csr_ port and
// should only change while the receiver idles.
`include "delimited_frame_receiver_xor_defines.svh"

module delimited_frame_receiver_xor import dfrx_pkg::*; #(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   dfrx_req_if.sink               req_ch,
   dfrx_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Address width of the buffer, and a count width that can hold BUFFER_BYTES.
   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = $clog2(BUFFER_BYTES + 1);

   // The sequencer: collect bytes, sweep the checksum, then hand out results.
   typedef enum logic [4:0] {
      ST_RECV   = 5'b00001,
      ST_SUM    = 5'b00010,
      ST_FETCH  = 5'b00100,
      ST_LOAD   = 5'b01000,
      ST_SINGLE = 5'b10000
   } state_type;

   typedef struct packed {
      status_type         status;
      logic [BYTE_W-1:0]  command_code;
      logic [COUNT_W-1:0] param_count;
      logic               param_valid;
      logic [COUNT_W-1:0] param_index;
      logic [BYTE_W-1:0]  param_byte;
      logic               last;
   } rsp_payload_type;

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] start_delim_ff, start_delim_in;
   logic [BYTE_W-1:0] end_delim_ff, end_delim_in;
   logic              in_frame_ff, in_frame_in;
   logic [CW-1:0]     byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [CW-1:0]     nparam_ff, nparam_in;
   logic [AW-1:0]     last_addr_ff, last_addr_in;
   logic [AW-1:0]     sum_addr_ff, sum_addr_in;
   logic              issue_done_ff, issue_done_in;
   logic              pend_ff, pend_in;
   logic [BYTE_W-1:0] acc_ff, acc_in;
   status_type        status_ff, status_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic [BYTE_W-1:0] frame_mem [BUFFER_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic              accept;
   logic              slot_free;
   logic              rsp_load;
   logic [CW-1:0]     count_inc;
   logic [CW-1:0]     checksum_pos;

   assign req_ch.ready = (state_ff == ST_RECV);
   assign accept       = req_ch.valid && req_ch.ready;
   assign count_inc    = byte_count_ff + CW'(1);
   // Position of the checksum byte: two below the count that includes the end byte.
   assign checksum_pos = count_inc - CW'(2);
   // A byte is buffered while a frame is open, and the start byte lands at entry zero.
   assign wr_en        = accept && (in_frame_ff || (req_ch.rx_byte == start_delim_ff));
   // The result register can take a new item when it is empty or being emptied now.
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in       = state_ff;
      start_delim_in = start_delim_ff;
      end_delim_in   = end_delim_ff;
      in_frame_in    = in_frame_ff;
      byte_count_in  = byte_count_ff;
      cmd_in         = cmd_ff;
      nparam_in      = nparam_ff;
      last_addr_in   = last_addr_ff;
      sum_addr_in    = sum_addr_ff;
      issue_done_in  = issue_done_ff;
      pend_in        = 1'b0;
      acc_in         = acc_ff;
      status_in      = status_ff;
      idx_in         = idx_ff;
      rd_addr        = '0;
      rsp_load       = 1'b0;
      rsp_in         = rsp_ff;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_START_DELIM: start_delim_in = csr_data;
            CSR_END_DELIM:   end_delim_in   = csr_data;
            default:         ;
         endcase
      end

      case (state_ff)
         ST_RECV: begin
            if (accept) begin
               if (!in_frame_ff) begin
                  if (req_ch.rx_byte == start_delim_ff) begin
                     in_frame_in   = 1'b1;
                     byte_count_in = CW'(1);
                  end
               end else begin
                  byte_count_in = count_inc;
                  if (byte_count_ff == CW'(1)) begin
                     cmd_in = req_ch.rx_byte;
                  end
                  if ((req_ch.rx_byte == end_delim_ff) &&
                      (count_inc >= CW'(MIN_FRAME_BYTES))) begin
                     // Frame closed: sweep from the command byte up to the checksum.
                     in_frame_in   = 1'b0;
                     byte_count_in = '0;
                     nparam_in     = count_inc - CW'(MIN_FRAME_BYTES);
                     last_addr_in  = checksum_pos[AW-1:0];
                     sum_addr_in   = AW'(1);
                     issue_done_in = 1'b0;
                     acc_in        = '0;
                     state_in      = ST_SUM;
                  end else if (count_inc >= CW'(BUFFER_BYTES)) begin
                     in_frame_in   = 1'b0;
                     byte_count_in = '0;
                     status_in     = STATUS_OVERFLOW;
                     state_in      = ST_SINGLE;
                  end
               end
            end
         end

         ST_SUM: begin
            // The XOR of command, parameters and checksum is zero for a good frame.
            if (!issue_done_ff) begin
               rd_addr       = sum_addr_ff;
               pend_in       = 1'b1;
               sum_addr_in   = sum_addr_ff + AW'(1);
               issue_done_in = (sum_addr_ff == last_addr_ff);
            end
            if (pend_ff) begin
               acc_in = acc_ff ^ rd_data_ff;
            end
            if (issue_done_ff && !pend_ff) begin
               if (acc_ff != '0) begin
                  status_in = STATUS_BAD_SUM;
                  state_in  = ST_SINGLE;
               end else if (nparam_ff == '0) begin
                  status_in = STATUS_OK;
                  state_in  = ST_SINGLE;
               end else begin
                  idx_in   = '0;
                  state_in = ST_FETCH;
               end
            end
         end

         ST_FETCH: begin
            // Parameters start two entries in, after the start and command bytes.
            rd_addr  = idx_ff[AW-1:0] + AW'(2);
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            // The same entry stays addressed so the read data holds while the sink stalls.
            rd_addr = idx_ff[AW-1:0] + AW'(2);
            if (slot_free) begin
               rsp_load            = 1'b1;
               rsp_in.status       = STATUS_OK;
               rsp_in.command_code = cmd_ff;
               rsp_in.param_count  = COUNT_W'(nparam_ff);
               rsp_in.param_valid  = 1'b1;
               rsp_in.param_index  = COUNT_W'(idx_ff);
               rsp_in.param_byte   = rd_data_ff;
               rsp_in.last         = (idx_ff == nparam_ff - CW'(1));
               if (idx_ff == nparam_ff - CW'(1)) begin
                  state_in = ST_RECV;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_FETCH;
               end
            end
         end

         ST_SINGLE: begin
            if (slot_free) begin
               rsp_load            = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.command_code = (status_ff == STATUS_OK) ? cmd_ff : '0;
               rsp_in.param_count  = '0;
               rsp_in.param_valid  = 1'b0;
               rsp_in.param_index  = '0;
               rsp_in.param_byte   = '0;
               rsp_in.last         = 1'b1;
               state_in            = ST_RECV;
            end
         end

         default: begin
            state_in = ST_RECV;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RECV;
         start_delim_ff <= START_DELIM_RESET;
         end_delim_ff   <= END_DELIM_RESET;
         in_frame_ff    <= 1'b0;
         byte_count_ff  <= '0;
         issue_done_ff  <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         start_delim_ff <= start_delim_in;
         end_delim_ff   <= end_delim_in;
         in_frame_ff    <= in_frame_in;
         byte_count_ff  <= byte_count_in;
         issue_done_ff  <= issue_done_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      nparam_ff    <= nparam_in;
      last_addr_ff <= last_addr_in;
      sum_addr_ff  <= sum_addr_in;
      acc_ff       <= acc_in;
      status_ff    <= status_in;
      idx_ff       <= idx_in;
      rsp_ff       <= rsp_in;
   end

   // Frame buffer: one write port for incoming bytes, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[byte_count_ff[AW-1:0]] <= req_ch.rx_byte;
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_ff.status;
   assign rsp_ch.command_code = rsp_ff.command_code;
   assign rsp_ch.param_count  = rsp_ff.param_count;
   assign rsp_ch.param_valid  = rsp_ff.param_valid;
   assign rsp_ch.param_index  = rsp_ff.param_index;
   assign rsp_ch.param_byte   = rsp_ff.param_byte;
   assign rsp_ch.last         = rsp_ff.last;

   // An error item never carries a command or a parameter and always ends its run.
   `DFRX_ASSERT_NOW(a_err_item_clean, clock, reset,
      rsp_valid_ff && (rsp_ff.status != STATUS_OK),
      (rsp_ff.command_code == '0) && !rsp_ff.param_valid && rsp_ff.last,
      "error result carries payload or is not last")
   // While a frame is open the byte count stays inside the buffer.
   `DFRX_ASSERT_NOW(a_count_in_range, clock, reset,
      in_frame_ff,
      (byte_count_ff != '0) && (byte_count_ff < CW'(BUFFER_BYTES)),
      "byte count outside the buffer while a frame is open")
   // Closing a frame, by end byte or by overflow, always clears the collection state.
   `DFRX_ASSERT_NOW(a_closed_outside_recv, clock, reset,
      state_ff != ST_RECV,
      !in_frame_ff && (byte_count_ff == '0),
      "frame still open while the sequencer is busy")
   // A fetched parameter is always followed by its load step.
   `DFRX_ASSERT_NEXT(a_fetch_then_load, clock, reset,
      state_ff == ST_FETCH,
      state_ff == ST_LOAD,
      "parameter fetch not followed by load")

endmodule
